// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ICAF_CHECK_IMPL(name, ck, rst_n, cond, prop) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("icaf check failed");

// next-cycle implication
`define ICAF_CHECK_NEXT(name, ck, rst_n, cond, prop) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("icaf check failed");

`endif

// ===== src/icaf_pkg.sv =====
// constants, types and functions shared by the attitude filter
`default_nettype none

package icaf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PRESCALE = 30 - SAMPLE_W;
	localparam int SQ_W = 2 * SAMPLE_W;
	localparam int RAD_W = SQ_W + 2 * PRESCALE;
	localparam int ROOT_W = RAD_W / 2;
	localparam int ROOT_CNT_W = $clog2(ROOT_W);
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int ATAN_IDX_W = 5;
	localparam int VEC_W = 34;
	localparam int ZW = 26;
	localparam int DEG_W = 9;
	localparam int MUL_W = 28;
	localparam int PROD_W = 2 * MUL_W;

	// reciprocals for exact truncating divides
	localparam logic [16:0] RECIP_131 = 17'd128072;
	localparam logic [26:0] RECIP_1000 = 27'd68719477;

	localparam logic signed [ZW-1:0] DEG90 = 26'sd5898240;
	localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;

	// atan(2^-i) in degrees * 65536
	function automatic logic signed [ZW-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			5'd0: v = 26'sd2949120;
			5'd1: v = 26'sd1740967;
			5'd2: v = 26'sd919879;
			5'd3: v = 26'sd466945;
			5'd4: v = 26'sd234379;
			5'd5: v = 26'sd117304;
			5'd6: v = 26'sd58666;
			5'd7: v = 26'sd29335;
			5'd8: v = 26'sd14668;
			5'd9: v = 26'sd7334;
			5'd10: v = 26'sd3667;
			5'd11: v = 26'sd1833;
			5'd12: v = 26'sd917;
			5'd13: v = 26'sd458;
			5'd14: v = 26'sd229;
			5'd15: v = 26'sd115;
			5'd16: v = 26'sd57;
			5'd17: v = 26'sd29;
			5'd18: v = 26'sd14;
			5'd19: v = 26'sd7;
			5'd20: v = 26'sd4;
			5'd21: v = 26'sd2;
			5'd22: v = 26'sd1;
			default: v = 26'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sd32767;
		end else if (v < -18'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/icaf_sqrt.sv =====
// digit-by-digit floor square root of the prescaled sum of squares
`default_nettype none

module icaf_sqrt import icaf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SQ_W-1:0]   sum_sq,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);

	logic                  run_q;
	logic                  done_q;
	logic [ROOT_CNT_W-1:0] cnt_q;
	logic [RAD_W-1:0]      rad_q;
	logic [32:0]           rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [32:0]           rem_sh;
	logic [32:0]           trial;
	logic                  take;

	always_comb begin
		rem_sh = {rem_q[30:0], rad_q[RAD_W-1 -: 2]};
		trial = {1'b0, root_q, 2'b01};
		take = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ROOT_CNT_W'(ROOT_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= {sum_sq, {(2 * PRESCALE){1'b0}}};
			rem_q <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== src/icaf_cordic.sv =====
// vectoring cordic giving atan2 in whole degrees, one rotation per cycle
`default_nettype none

module icaf_cordic import icaf_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [VEC_W-1:0] y_in,
	input  wire logic signed [VEC_W-1:0] x_in,
	output logic                         done,
	output logic signed [DEG_W-1:0]      deg
);

	logic                    run_q;
	logic                    fin_q;
	logic                    done_q;
	logic [STEP_W-1:0]       i_q;
	logic signed [VEC_W-1:0] y_q;
	logic signed [VEC_W-1:0] x_q;
	logic signed [ZW-1:0]    z_q;
	logic                    ypos_q;
	logic                    yzero_q;
	logic                    xneg_q;
	logic                    xzero_q;
	logic signed [DEG_W-1:0] deg_q;

	logic signed [VEC_W-1:0] ys;
	logic signed [VEC_W-1:0] xs;
	logic signed [ZW-1:0]    ang;
	logic signed [ZW-1:0]    zz;
	logic signed [ZW-1:0]    zt;
	logic signed [DEG_W-1:0] deg_c;
	logic                    xpos;

	always_comb begin
		ys = y_q >>> i_q;
		xs = x_q >>> i_q;
		ang = atan_q16(ATAN_IDX_W'(i_q));
	end

	// quadrant fold, clamp and truncate toward zero, with exact results on the axes
	always_comb begin
		xpos = !xneg_q && !xzero_q;
		zz = z_q;
		if (xneg_q) begin
			zz = ypos_q ? DEG180 - z_q : -DEG180 - z_q;
		end
		if (ypos_q) begin
			if (zz < 0) zz = '0;
			if (zz > DEG180) zz = DEG180;
			if (xpos && zz > DEG90) zz = DEG90;
			if (xneg_q && zz < DEG90) zz = DEG90;
		end else begin
			if (zz > 0) zz = '0;
			if (zz < -DEG180) zz = -DEG180;
			if (xpos && zz < -DEG90) zz = -DEG90;
			if (xneg_q && zz > -DEG90) zz = -DEG90;
		end
		zt = zz[ZW-1] ? (zz + 26'sd65535) >>> 16 : zz >>> 16;
		deg_c = zt[DEG_W-1:0];
		if (yzero_q) begin
			deg_c = xneg_q ? 9'sd180 : 9'sd0;
		end else if (xzero_q) begin
			deg_c = ypos_q ? 9'sd90 : -9'sd90;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q <= '0;
			end else if (run_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q <= y_in;
			x_q <= x_in[VEC_W-1] ? -x_in : x_in;
			z_q <= '0;
			ypos_q <= y_in > 0;
			yzero_q <= y_in == 0;
			xneg_q <= x_in[VEC_W-1];
			xzero_q <= x_in == 0;
		end else if (run_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end
		end
		if (fin_q) begin
			deg_q <= deg_c;
		end
	end

	assign done = done_q;
	assign deg = deg_q;

endmodule

`default_nettype wire

// ===== src/imu_complementary_attitude_filter_unit.sv =====
// Complementary attitude filter, one IMU sample in, one attitude result out.
// Input channel (in_valid/in_ready) carries accel, gyro, magnetometer xy and the
// elapsed milliseconds; output channel (out_valid/out_ready) carries roll, pitch,
// blended yaw, gyro yaw and magnetometer heading in whole degrees.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes gyro biases and
// the alpha and beta gyro weights by register index; other indexes are ignored.
// Steps of a sample: the gyro path for each of the three axes, then for each tilt
// angle the squares, a 30-step square root and a 16-step cordic, then the heading
// cordic, the three blends and the load of the output register. One shared 28x28
// multiplier serves the gyro divides and integration, the squares and the blends.
// One sample is processed at a time; in_ready is high only when the sequencer is
// idle, which it is again as soon as the result sits in the output register, so a
// new sample is accepted only once the previous one is through.
// If the receiver stalls, the result holds and a following sample is worked on,
// then waits until the output register is free.
// Reset clears the kept angles to zero, biases to zero, weights to 62915.
`default_nettype none
`include "assert_macros.svh"

module imu_complementary_attitude_filter_unit import icaf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] rate_x,
	input  wire logic signed [15:0] rate_y,
	input  wire logic signed [15:0] rate_z,
	input  wire logic signed [15:0] field_x,
	input  wire logic signed [15:0] field_y,
	input  wire logic [15:0]        elapsed_ms,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      roll_deg,
	output logic signed [15:0]      pitch_deg,
	output logic signed [15:0]      yaw_deg,
	output logic signed [15:0]      yaw_gyro_deg,
	output logic signed [8:0]       yaw_mag_deg
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_GYRO  = 8'b0000_0010,
		ST_SQ    = 8'b0000_0100,
		ST_ROOT  = 8'b0000_1000,
		ST_ANGLE = 8'b0001_0000,
		ST_MAG   = 8'b0010_0000,
		ST_BLEND = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		REG_BIAS_X = 3'd0,
		REG_BIAS_Y = 3'd1,
		REG_BIAS_Z = 3'd2,
		REG_ALPHA  = 3'd3,
		REG_BETA   = 3'd4
	} cfg_reg_t;

	localparam logic [1:0] JOB_ROLL = 2'd0;
	localparam logic [1:0] JOB_PITCH = 2'd1;
	localparam logic [1:0] JOB_MAG = 2'd2;

	state_t state_q;
	logic [1:0] ax_q;
	logic [2:0] ph_q;
	logic [1:0] job_q;

	logic signed [15:0] bias_q [3];
	logic [15:0]        alpha_q;
	logic [15:0]        beta_q;
	logic signed [15:0] kept_q [3];

	logic signed [15:0] accel_q [3];
	logic signed [15:0] rate_q [3];
	logic signed [15:0] fx_q;
	logic signed [15:0] fy_q;
	logic [15:0]        ms_q;

	logic signed [MUL_W-1:0]  mul_a_q;
	logic signed [MUL_W-1:0]  mul_b_q;
	logic signed [MUL_W-1:0]  mul_a_d;
	logic signed [MUL_W-1:0]  mul_b_d;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [33:0]       acc_q;
	logic                     dneg_q;
	logic                     nneg_q;
	logic signed [15:0]       gint_q [3];
	logic signed [DEG_W-1:0]  ang_q [3];

	logic                     out_valid_q;
	logic signed [15:0]       roll_q;
	logic signed [15:0]       pitch_q;
	logic signed [15:0]       yaw_q;
	logic signed [15:0]       yawg_q;
	logic signed [DEG_W-1:0]  yawm_q;

	logic in_fire;
	logic out_free;

	logic signed [16:0] gd;
	logic [16:0]        gad;
	logic signed [9:0]  gq;
	logic signed [26:0] kx;
	logic signed [26:0] k1000;
	logic signed [26:0] nsum;
	logic signed [26:0] nabs;
	logic [16:0]        q1000;
	logic signed [17:0] gsv;
	logic signed [15:0] gint_c;
	logic signed [33:0] vsum;
	logic signed [33:0] vsh;
	logic signed [15:0] blend_c;
	logic [SQ_W-1:0]    sq_sum;
	logic signed [15:0] sq_a;
	logic signed [16:0] tilt_num;
	logic [15:0]        bw;

	logic                    sq_done;
	logic [ROOT_W-1:0]       sq_root;
	logic                    co_start;
	logic                    co_done;
	logic signed [DEG_W-1:0] co_deg;
	logic signed [VEC_W-1:0] co_y;
	logic signed [VEC_W-1:0] co_x;

	assign cfg_ready = 1'b1;
	assign in_ready = state_q == ST_IDLE;
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// gyro path: bias, divide by 131, integrate, divide by 1000
	always_comb begin
		gd = {rate_q[ax_q][15], rate_q[ax_q]} - {bias_q[ax_q][15], bias_q[ax_q]};
		gad = gd[16] ? 17'(-gd) : 17'(gd);
		gq = dneg_q ? -$signed(prod_q[33:24]) : $signed(prod_q[33:24]);
		kx = 27'(kept_q[ax_q]);
		k1000 = (kx <<< 10) - (kx <<< 4) - (kx <<< 3);
		nsum = $signed(prod_q[26:0]) + k1000;
		nabs = nsum[26] ? -nsum : nsum;
		q1000 = prod_q[52:36];
		gsv = nneg_q ? -$signed({1'b0, q1000}) : $signed({1'b0, q1000});
		gint_c = sat16(gsv);
	end

	// blend and tilt operands
	always_comb begin
		vsum = acc_q + $signed(prod_q[33:0]);
		vsh = vsum[33] ? (vsum + 34'sd65535) >>> 16 : vsum >>> 16;
		blend_c = sat16(vsh[17:0]);
		sq_sum = acc_q[SQ_W-1:0] + prod_q[SQ_W-1:0];
		sq_a = (job_q == JOB_ROLL) ? accel_q[0] : accel_q[1];
		tilt_num = (job_q == JOB_ROLL) ? -17'(accel_q[1]) : 17'(accel_q[0]);
		bw = (ax_q == 2'd2) ? beta_q : alpha_q;
	end

	always_comb begin
		if (state_q == ST_MAG) begin
			co_y = VEC_W'(fx_q) <<< PRESCALE;
			co_x = VEC_W'(fy_q) <<< PRESCALE;
		end else begin
			co_y = VEC_W'(tilt_num) <<< PRESCALE;
			co_x = VEC_W'(sq_root);
		end
		co_start = (state_q == ST_MAG) || (state_q == ST_ROOT && sq_done);
	end

	// operands of the shared multiplier
	always_comb begin
		mul_a_d = mul_a_q;
		mul_b_d = mul_b_q;
		unique case (state_q)
			ST_GYRO: begin
				unique case (ph_q)
					3'd0: begin
						mul_a_d = MUL_W'(gad);
						mul_b_d = MUL_W'(RECIP_131);
					end
					3'd2: begin
						mul_a_d = MUL_W'(gq);
						mul_b_d = MUL_W'(ms_q);
					end
					3'd4: begin
						mul_a_d = MUL_W'(nabs);
						mul_b_d = MUL_W'(RECIP_1000);
					end
					default: begin
					end
				endcase
			end
			ST_SQ: begin
				unique case (ph_q)
					3'd0: begin
						mul_a_d = MUL_W'(sq_a);
						mul_b_d = MUL_W'(sq_a);
					end
					3'd2: begin
						mul_a_d = MUL_W'(accel_q[2]);
						mul_b_d = MUL_W'(accel_q[2]);
					end
					default: begin
					end
				endcase
			end
			ST_BLEND: begin
				unique case (ph_q)
					3'd0: begin
						mul_a_d = MUL_W'(bw);
						mul_b_d = MUL_W'(gint_q[ax_q]);
					end
					3'd2: begin
						mul_a_d = MUL_W'(17'd65536 - {1'b0, bw});
						mul_b_d = MUL_W'(ang_q[ax_q]);
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	icaf_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SQ && ph_q == 3'd4),
		.sum_sq (sq_sum),
		.done   (sq_done),
		.root   (sq_root)
	);

	icaf_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (co_start),
		.y_in   (co_y),
		.x_in   (co_x),
		.done   (co_done),
		.deg    (co_deg)
	);

	// sequencer, configuration and kept angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q <= '0;
			ph_q <= '0;
			job_q <= JOB_ROLL;
			alpha_q <= 16'd62915;
			beta_q <= 16'd62915;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				bias_q[i] <= '0;
				kept_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_BIAS_X: bias_q[0] <= cfg_data;
					REG_BIAS_Y: bias_q[1] <= cfg_data;
					REG_BIAS_Z: bias_q[2] <= cfg_data;
					REG_ALPHA: alpha_q <= cfg_data;
					REG_BETA: beta_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_GYRO;
						ax_q <= '0;
						ph_q <= '0;
					end
				end
				ST_GYRO: begin
					if (ph_q == 3'd6) begin
						ph_q <= '0;
						if (ax_q == 2'd2) begin
							ax_q <= '0;
							job_q <= JOB_ROLL;
							state_q <= ST_SQ;
						end else begin
							ax_q <= ax_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_SQ: begin
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						state_q <= ST_ROOT;
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_ROOT: begin
					if (sq_done) begin
						state_q <= ST_ANGLE;
					end
				end
				ST_ANGLE: begin
					if (co_done) begin
						if (job_q == JOB_MAG) begin
							ax_q <= '0;
							ph_q <= '0;
							state_q <= ST_BLEND;
						end else if (job_q == JOB_PITCH) begin
							job_q <= JOB_MAG;
							state_q <= ST_MAG;
						end else begin
							job_q <= JOB_PITCH;
							state_q <= ST_SQ;
						end
					end
				end
				ST_MAG: begin
					state_q <= ST_ANGLE;
				end
				ST_BLEND: begin
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						kept_q[ax_q] <= blend_c;
						if (ax_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							ax_q <= ax_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			accel_q[0] <= accel_x;
			accel_q[1] <= accel_y;
			accel_q[2] <= accel_z;
			rate_q[0] <= rate_x;
			rate_q[1] <= rate_y;
			rate_q[2] <= rate_z;
			fx_q <= field_x;
			fy_q <= field_y;
			ms_q <= elapsed_ms;
		end
		mul_a_q <= mul_a_d;
		mul_b_q <= mul_b_d;
		prod_q <= mul_a_q * mul_b_q;
		if (state_q == ST_GYRO && ph_q == 3'd0) begin
			dneg_q <= gd[16];
		end
		if (state_q == ST_GYRO && ph_q == 3'd4) begin
			nneg_q <= nsum[26];
		end
		if (state_q == ST_GYRO && ph_q == 3'd6) begin
			gint_q[ax_q] <= gint_c;
		end
		if (state_q == ST_SQ && ph_q == 3'd2) begin
			acc_q <= {2'b00, prod_q[31:0]};
		end
		if (state_q == ST_BLEND && ph_q == 3'd2) begin
			acc_q <= $signed(prod_q[33:0]);
		end
		if (state_q == ST_ANGLE && co_done) begin
			ang_q[job_q] <= (job_q == JOB_MAG) ? -co_deg : co_deg;
		end
		if (state_q == ST_DONE && out_free) begin
			roll_q <= kept_q[0];
			pitch_q <= kept_q[1];
			yaw_q <= kept_q[2];
			yawg_q <= gint_q[2];
			yawm_q <= ang_q[2];
		end
	end

	assign out_valid = out_valid_q;
	assign roll_deg = roll_q;
	assign pitch_deg = pitch_q;
	assign yaw_deg = yaw_q;
	assign yaw_gyro_deg = yawg_q;
	assign yaw_mag_deg = yawm_q;

	`ICAF_CHECK_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ICAF_CHECK_IMPL(a_root_in_wait, clk, arst_n, sq_done, state_q == ST_ROOT)
	`ICAF_CHECK_IMPL(a_angle_in_wait, clk, arst_n, co_done, state_q == ST_ANGLE)
	`ICAF_CHECK_IMPL(a_heading_range, clk, arst_n, out_valid, yaw_mag_deg >= -9'sd180 && yaw_mag_deg <= 9'sd180)

endmodule

`default_nettype wire
